>>> design/reserving_memory_port_with_watchpoints_assert.svh
// Assertion macros for the reserving memory port with watchpoints.
`ifndef RESERVING_MEMORY_PORT_WITH_WATCHPOINTS_ASSERT_SVH
`define RESERVING_MEMORY_PORT_WITH_WATCHPOINTS_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, clocked on clk, off during reset
`define RMPW_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rmpw assertion failed");
// next-cycle implication, clocked on clk, off during reset
`define RMPW_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rmpw assertion failed");
`else
`define RMPW_ASSERT_IMP(lbl, pre, post)
`define RMPW_ASSERT_NXT(lbl, pre, post)
`endif

`endif

>>> design/rmpw_pkg.sv
// Shared types, constants and helper functions of the reserving memory port.
package rmpw_pkg;

  localparam int ADDR_W    = 32;
  localparam int DATA_W    = 64;
  localparam int MASK_W    = 8;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int WCNT_W    = 3;
  localparam int LOW_W     = 29;

  // configuration register indexes
  localparam int REG_SEED_Z    = 0;
  localparam int REG_SEED_W    = 1;
  localparam int REG_WATCH_CNT = 2;
  localparam int REG_WATCH_0   = 3;
  localparam int WATCH_REGS    = 4;

  // generator constants
  localparam logic [15:0] MWC_Z_MUL  = 16'd36969;
  localparam logic [15:0] MWC_W_MUL  = 16'd18000;
  localparam logic [31:0] SEED_Z_RST = 32'd88888888;
  localparam logic [31:0] SEED_W_RST = 32'd12345678;

  // upper address bits that keep an address unmasked
  localparam logic [2:0] HIGH_SEL = 3'b111;

  // byte-mask codes
  localparam logic [7:0] BM_ALL = 8'hFF;
  localparam logic [7:0] BM_TOP3 = 8'hE0;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic              rsv;    // reserving read commits
    logic              clr;    // conditional write clears matching slots
    logic [ADDR_W-1:0] addr;   // masked address of the item
  } resv_req_t;

  // addresses outside the top region are folded to 29 bits
  function automatic logic [ADDR_W-1:0] mask_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    if (a[ADDR_W-1 -: 3] == HIGH_SEL) r = a;
    else r = {3'b000, a[LOW_W-1:0]};
    return r;
  endfunction

  function automatic logic mask_supported(input logic [MASK_W-1:0] m);
    logic ok;
    case (m)
      BM_ALL, BM_TOP3,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h03, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'hC0,
      8'h0F, 8'h1E, 8'h3C, 8'h78, 8'hF0: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // index of lowest enabled byte
  function automatic logic [2:0] mask_lowest(input logic [MASK_W-1:0] m);
    logic [2:0] lo;
    lo = 3'd0;
    for (int b = MASK_W - 1; b >= 0; b--) begin
      if (m[b]) lo = 3'(b);
    end
    return lo;
  endfunction

  // byte enables expanded to bit enables
  function automatic logic [DATA_W-1:0] mask_bits(input logic [MASK_W-1:0] m);
    logic [DATA_W-1:0] bits;
    for (int b = 0; b < MASK_W; b++) begin
      bits[8*b +: 8] = {8{m[b]}};
    end
    return bits;
  endfunction

endpackage

>>> design/rmpw_in_if.sv
// Input item channel: one memory access.
interface rmpw_in_if import rmpw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] address;
  logic              reserve;
  logic              conditional;
  logic [DATA_W-1:0] write_data;
  logic [MASK_W-1:0] byte_mask;

  modport source (output valid, action, address, reserve, conditional, write_data,
                  byte_mask, input ready);
  modport sink (input valid, action, address, reserve, conditional, write_data,
                byte_mask, output ready);
endinterface

>>> design/rmpw_out_if.sv
// Result item channel: read data and write status.
interface rmpw_out_if import rmpw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              write_done;
  logic              watch_hit;

  modport source (output valid, read_data, write_done, watch_hit, input ready);
  modport sink (input valid, read_data, write_done, watch_hit, output ready);
endinterface

>>> design/rmpw_cfg_if.sv
// Configuration write channel: register index and data.
interface rmpw_cfg_if import rmpw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/rmpw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module rmpw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/rmpw_resv.sv
// Reservation slots and multiply-with-carry replacement generator.
module rmpw_resv import rmpw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg,
  input  resv_req_t req,
  output logic      match
);

  logic [ADDR_W-1:0] res_a_r, res_a_nxt;
  logic [ADDR_W-1:0] res_b_r, res_b_nxt;
  logic [31:0]       z_r, z_nxt;
  logic [31:0]       w_r, w_nxt;
  logic [31:0]       z_step, w_step;
  logic              match_a, match_b;

  assign match_a = (req.addr == res_a_r);
  assign match_b = (req.addr == res_b_r);
  assign match   = match_a | match_b;

  // one generator step: 16x16 product plus carry half
  assign z_step = ({16'd0, MWC_Z_MUL} * {16'd0, z_r[15:0]}) + {16'd0, z_r[31:16]};
  assign w_step = ({16'd0, MWC_W_MUL} * {16'd0, w_r[15:0]}) + {16'd0, w_r[31:16]};

  // slot update on commit, seed loads on config writes
  always_comb begin
    res_a_nxt = res_a_r;
    res_b_nxt = res_b_r;
    z_nxt     = z_r;
    w_nxt     = w_r;
    if (req.rsv) begin
      if (res_a_r == '0) begin
        res_a_nxt = req.addr;
      end else if (res_b_r == '0) begin
        res_b_nxt = req.addr;
      end else begin
        z_nxt = z_step;
        w_nxt = w_step;
        if (w_step[0]) res_b_nxt = req.addr;
        else res_a_nxt = req.addr;
      end
    end
    if (req.clr) begin
      if (match_a) res_a_nxt = '0;
      if (match_b) res_b_nxt = '0;
    end
    if (cfg.we && cfg.idx == CFG_IDX_W'(REG_SEED_Z)) z_nxt = cfg.data;
    if (cfg.we && cfg.idx == CFG_IDX_W'(REG_SEED_W)) w_nxt = cfg.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_a_r <= '0;
      res_b_r <= '0;
      z_r     <= SEED_Z_RST;
      w_r     <= SEED_W_RST;
    end else begin
      res_a_r <= res_a_nxt;
      res_b_r <= res_b_nxt;
      z_r     <= z_nxt;
      w_r     <= w_nxt;
    end
  end

endmodule

>>> design/rmpw_watch.sv
// Data watchpoint registers and address compare.
module rmpw_watch import rmpw_pkg::*; #(
  parameter int WATCH_SLOTS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_wr_t           cfg,
  input  logic [ADDR_W-1:0] addr,
  output logic              hit
);

  logic [WCNT_W-1:0]      watch_count_r;
  logic [ADDR_W-1:0]      watch_addr_r [WATCH_SLOTS];
  logic [WATCH_SLOTS-1:0] slot_hit;

  // active-slot count; values above the slot count cover all slots
  always_ff @(posedge clk) begin
    if (!rst_n) watch_count_r <= '0;
    else if (cfg.we && cfg.idx == CFG_IDX_W'(REG_WATCH_CNT))
      watch_count_r <= cfg.data[WCNT_W-1:0];
  end

  for (genvar i = 0; i < WATCH_SLOTS; i++) begin : g_slot
    if (i < WATCH_REGS) begin : g_wr
      always_ff @(posedge clk) begin
        if (!rst_n) watch_addr_r[i] <= '0;
        else if (cfg.we && cfg.idx == CFG_IDX_W'(REG_WATCH_0 + i))
          watch_addr_r[i] <= cfg.data;
      end
    end else begin : g_fixed
      // slot without a register of its own stays zero
      assign watch_addr_r[i] = '0;
    end
    assign slot_hit[i] = ({1'b0, watch_count_r} > 4'(i)) && (watch_addr_r[i] == addr);
  end

  assign hit = |slot_hit;

endmodule

>>> design/reserving_memory_port_with_watchpoints.sv
// Top level: reserving main-memory port with data watchpoints.
// Usage:
//   in_ch  carries one access (read or write) per item; ready is high whenever
//          no access is in flight and the store is not being cleared.
//   out_ch returns one result item per access, held in an output register
//          until taken; a new access may be accepted while it waits.
//   cfg_ch writes seeds, watchpoint count and addresses; always ready.
// Timing: the store RAM read is issued in the cycle that an access is
//   accepted; the registered read data is then merged, written back and
//   loaded into the output register in state S_RD, unless the output
//   register is still full. A new access is accepted only after the current
//   one has committed from S_RD.
// Reset: rst_n (synchronous, active low) clears reservations, loads the
//   generator seeds and starts a clearing pass that zeroes the store one word
//   per cycle, all 2**STORE_WORDS_LOG2 words; no item is accepted meanwhile, but
//   configuration writes are.
// Stall: if the output register is still full, the access waits with its
//   read data held and in_ch stays not ready until the result is taken.
module reserving_memory_port_with_watchpoints import rmpw_pkg::*; #(
  parameter int STORE_WORDS_LOG2 = 14,
  parameter int WATCH_SLOTS      = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  rmpw_in_if.sink     in_ch,
  rmpw_out_if.source  out_ch,
  rmpw_cfg_if.sink    cfg_ch
);

  `include "reserving_memory_port_with_watchpoints_assert.svh"

  localparam int IDX_W = STORE_WORDS_LOG2;

  // state codes
  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;

  // item registers
  logic              act_r;
  logic [ADDR_W-1:0] ad_r;
  logic              rsv_r;
  logic              cond_r;
  logic [DATA_W-1:0] wdata_r;
  logic [MASK_W-1:0] mask_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] read_data_r;
  logic              write_done_r;
  logic              watch_hit_r;

  logic              accept, commit;
  logic [ADDR_W-1:0] ad_in;
  logic              in_main;
  logic              match, hit;
  logic              wr_ok;
  logic [DATA_W-1:0] bits, shifted, merged;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  cfg_wr_t           cfg_wr;
  resv_req_t         resv_req;

  // configuration port
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.we    = cfg_ch.valid & cfg_ch.ready;
  assign cfg_wr.idx   = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  // handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid & in_ch.ready;
  assign commit      = (state_r == S_RD) && (!out_valid_r || out_ch.ready);

  assign ad_in   = mask_addr(in_ch.address);
  assign in_main = (ad_r[ADDR_W-1:27] == '0);

  // capture the access
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_ch.action;
      ad_r    <= ad_in;
      rsv_r   <= in_ch.reserve;
      cond_r  <= in_ch.conditional;
      wdata_r <= in_ch.write_data;
      mask_r  <= in_ch.byte_mask;
    end
  end

  // sequencer: clearing pass, idle, read-modify-write
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      S_CLR: begin
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_RD;
      end
      S_RD: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // byte merge
  assign wr_ok   = act_r && (!cond_r || match);
  assign bits    = mask_bits(mask_r);
  assign shifted = wdata_r << {mask_lowest(mask_r), 3'b000};
  assign merged  = (ram_rdata & ~bits) | (shifted & bits);

  // store RAM access
  assign ram_re    = accept;
  assign ram_raddr = ad_in[IDX_W+2:3];
  assign ram_we    = (state_r == S_CLR) ||
                     (commit && wr_ok && in_main && mask_supported(mask_r));
  assign ram_waddr = (state_r == S_CLR) ? clr_idx_r : ad_r[IDX_W+2:3];
  assign ram_wdata = (state_r == S_CLR) ? '0 : merged;

  rmpw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (2 ** STORE_WORDS_LOG2)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // reservations
  assign resv_req.rsv  = commit && !act_r && rsv_r;
  assign resv_req.clr  = commit && act_r && cond_r;
  assign resv_req.addr = ad_r;

  rmpw_resv u_resv (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .req   (resv_req),
    .match (match)
  );

  // watchpoints
  rmpw_watch #(
    .WATCH_SLOTS (WATCH_SLOTS)
  ) u_watch (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .addr  (ad_r),
    .hit   (hit)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      read_data_r  <= (!act_r && in_main) ? ram_rdata : '0;
      write_done_r <= !(act_r && cond_r && !match);
      watch_hit_r  <= act_r && hit;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = read_data_r;
  assign out_ch.write_done = write_done_r;
  assign out_ch.watch_hit  = watch_hit_r;

  // checks
  `RMPW_ASSERT_IMP(a_no_accept_in_clear, state_r == S_CLR, !in_ch.ready)
  `RMPW_ASSERT_NXT(a_accept_to_read, accept, state_r == S_RD)
  `RMPW_ASSERT_IMP(a_store_write_is_write, ram_we && state_r != S_CLR, commit && act_r)
  `RMPW_ASSERT_NXT(a_commit_fills_output, commit, out_valid_r)

endmodule

>>> sim/reserving_memory_port_with_watchpoints_tb.sv
// Self-checking testbench for the reserving memory port with data watchpoints.
`timescale 1ns / 100ps

module reserving_memory_port_with_watchpoints_tb;
  import rmpw_pkg::*;

  localparam int STORE_LOG2    = 14;
  localparam int STORE_WORDS   = 1 << STORE_LOG2;
  localparam int WATCH_SLOTS   = 4;
  localparam int REG_COUNT     = REG_WATCH_0 + WATCH_REGS;
  localparam int HOT_N         = 8;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 620;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [31:0] MAIN_LIMIT = 32'd134217728;
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] address;
    logic              reserve;
    logic              conditional;
    logic [DATA_W-1:0] write_data;
    logic [MASK_W-1:0] byte_mask;
  } mem_access_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              write_done;
    logic              watch_hit;
  } port_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  rmpw_in_if  in_ch();
  rmpw_out_if out_ch();
  rmpw_cfg_if cfg_ch();

  reserving_memory_port_with_watchpoints #(
    .STORE_WORDS_LOG2(STORE_LOG2),
    .WATCH_SLOTS(WATCH_SLOTS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow state of the port
  logic [DATA_W-1:0] store_words [STORE_WORDS];
  logic [31:0]       resv_a, resv_b;
  logic [31:0]       gen_z, gen_w;
  logic [2:0]        watch_cnt;
  logic [31:0]       watch_tab [WATCH_REGS];

  port_reply_t pending_replies [$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  logic [31:0] hot_addr [HOT_N];

  task automatic reset_shadow();
    foreach (store_words[i]) store_words[i] = '0;
    foreach (watch_tab[i]) watch_tab[i] = '0;
    resv_a    = '0;
    resv_b    = '0;
    gen_z     = SEED_Z_RST;
    gen_w     = SEED_W_RST;
    watch_cnt = '0;
  endtask

  task automatic apply_config(input int idx, input logic [31:0] value);
    case (idx)
      REG_SEED_Z:    gen_z = value;
      REG_SEED_W:    gen_w = value;
      REG_WATCH_CNT: watch_cnt = value[2:0];
      default: begin
        if (idx >= REG_WATCH_0 && idx < REG_COUNT) watch_tab[idx - REG_WATCH_0] = value;
      end
    endcase
  endtask

  // effect of one access on the shadow state, and the reply it should produce
  task automatic apply_access(input mem_access_t acc, output port_reply_t rep);
    logic [31:0]           ad;
    logic                  in_main;
    logic [STORE_LOG2-1:0] widx;
    logic [DATA_W-1:0]     bits;
    logic [7:0]            run;
    logic                  mask_ok;
    int                    lo;
    int                    n_on;
    int                    n_watch;
    ad = acc.address;
    if (ad[31:29] != 3'b111) ad[31:29] = 3'b000;
    in_main = (ad < MAIN_LIMIT);
    widx    = ad[3 +: STORE_LOG2];
    rep.read_data  = '0;
    rep.write_done = 1'b1;
    rep.watch_hit  = 1'b0;
    if (acc.action == ACT_READ) begin
      if (acc.reserve) begin
        if (resv_a == 0) begin
          resv_a = ad;
        end else if (resv_b == 0) begin
          resv_b = ad;
        end else begin
          // both slots taken: generator picks the victim
          gen_z = {16'd0, MWC_Z_MUL} * {16'd0, gen_z[15:0]} + {16'd0, gen_z[31:16]};
          gen_w = {16'd0, MWC_W_MUL} * {16'd0, gen_w[15:0]} + {16'd0, gen_w[31:16]};
          if (gen_w[0]) resv_b = ad;
          else resv_a = ad;
        end
      end
      if (in_main) rep.read_data = store_words[widx];
    end else begin
      if (acc.conditional && ad != resv_a && ad != resv_b) begin
        rep.write_done = 1'b0;
      end else begin
        if (acc.conditional) begin
          if (ad == resv_a) resv_a = '0;
          if (ad == resv_b) resv_b = '0;
        end
        // legal masks: one contiguous run of 1, 2, 4 or 8 bytes, or the top three
        lo = 0;
        while (lo < 8 && !acc.byte_mask[lo]) lo++;
        run     = acc.byte_mask >> lo;
        n_on    = $countones(acc.byte_mask);
        mask_ok = (acc.byte_mask != 0) && ((run & (run + 8'd1)) == 8'd0) &&
                  (n_on == 1 || n_on == 2 || n_on == 4 || n_on == 8 ||
                   acc.byte_mask == BM_TOP3);
        if (in_main && mask_ok) begin
          for (int b = 0; b < 8; b++) bits[8*b +: 8] = {8{acc.byte_mask[b]}};
          store_words[widx] = (store_words[widx] & ~bits) |
                              ((acc.write_data << (8 * lo)) & bits);
        end
      end
      n_watch = (watch_cnt > WATCH_SLOTS) ? WATCH_SLOTS : int'(watch_cnt);
      for (int k = 0; k < n_watch; k++) begin
        if (watch_tab[k] == ad) rep.watch_hit = 1'b1;
      end
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] exp_v, act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  // check replies, track config writes and predict each accepted item
  always @(posedge clk) begin : port_monitor
    port_reply_t want;
    port_reply_t got;
    mem_access_t acc;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.read_data  = out_ch.read_data;
        got.write_done = out_ch.write_done;
        got.watch_hit  = out_ch.watch_hit;
        if (pending_replies.size() == 0) begin
          note_mismatch("result with no access pending", 64'd0, got.read_data);
        end else begin
          want = pending_replies.pop_front();
          if (got.read_data !== want.read_data)
            note_mismatch("read_data", want.read_data, got.read_data);
          if (got.write_done !== want.write_done)
            note_mismatch("write_done", 64'(want.write_done), 64'(got.write_done));
          if (got.watch_hit !== want.watch_hit)
            note_mismatch("watch_hit", 64'(want.watch_hit), 64'(got.watch_hit));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) apply_config(int'(cfg_ch.index), cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        acc.action      = in_ch.action;
        acc.address     = in_ch.address;
        acc.reserve     = in_ch.reserve;
        acc.conditional = in_ch.conditional;
        acc.write_data  = in_ch.write_data;
        acc.byte_mask   = in_ch.byte_mask;
        apply_access(acc, want);
        pending_replies.push_back(want);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // drive one item, wait until it is taken; called and returns at a falling edge
  task automatic send_access(input mem_access_t acc);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= acc.action;
    in_ch.address     <= acc.address;
    in_ch.reserve     <= acc.reserve;
    in_ch.conditional <= acc.conditional;
    in_ch.write_data  <= acc.write_data;
    in_ch.byte_mask   <= acc.byte_mask;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // write every register in index order
  task automatic configure(input logic [31:0] z, w, input logic [2:0] cnt,
                           input logic [31:0] watch [WATCH_REGS]);
    logic [31:0] regs [REG_COUNT];
    regs[REG_SEED_Z]    = z;
    regs[REG_SEED_W]    = w;
    regs[REG_WATCH_CNT] = {29'd0, cnt};
    for (int k = 0; k < WATCH_REGS; k++) regs[REG_WATCH_0 + k] = watch[k];
    for (int r = 0; r < REG_COUNT; r++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CFG_IDX_W'(r);
      cfg_ch.data  <= regs[r];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // stop offering and wait for every outstanding reply
  task automatic drain_port();
    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic mem_access_t make_access(input logic act, input logic [31:0] addr,
                                              input logic rsv, cond,
                                              input logic [63:0] data, input logic [7:0] m);
    mem_access_t a;
    a.action      = act;
    a.address     = addr;
    a.reserve     = rsv;
    a.conditional = cond;
    a.write_data  = data;
    a.byte_mask   = m;
    return a;
  endfunction

  // small set of masked addresses so reservations, watchpoints and re-reads meet
  task automatic refresh_hot_addrs();
    hot_addr[0] = '0;
    for (int k = 1; k < 5; k++) hot_addr[k] = {21'd0, 8'($urandom), 3'($urandom)};
    hot_addr[5] = $urandom & 32'h07FF_FFFF;
    hot_addr[6] = ($urandom & 32'h1FFF_FFFF) | 32'h0800_0000;
    hot_addr[7] = $urandom | 32'hE000_0000;
  endtask

  task automatic random_access(output mem_access_t acc);
    int          pick;
    logic [31:0] base;
    pick = $urandom_range(0, 99);
    acc.action      = (pick < 45) ? ACT_READ : ACT_WRITE;
    // reserve only matters on reads, conditional only on writes
    acc.reserve     = (pick < 25) ? 1'b0 : (pick < 45) ? 1'b1 : 1'($urandom);
    acc.conditional = (pick < 45) ? 1'($urandom) : (pick >= 70);
    base = hot_addr[$urandom_range(0, HOT_N - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      // same masked address, different folded-away top bits
      if (base[31:29] != 3'b111) base[31:29] = 3'($urandom_range(0, 6));
    end else if (pick < 90) begin
      base[26:17] = 10'($urandom);
    end else begin
      base = $urandom;
    end
    acc.address    = base;
    acc.write_data = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 75) begin
      case ($urandom_range(0, 4))
        0:       acc.byte_mask = 8'h01 << $urandom_range(0, 7);
        1:       acc.byte_mask = 8'h03 << $urandom_range(0, 6);
        2:       acc.byte_mask = 8'h0F << $urandom_range(0, 4);
        3:       acc.byte_mask = BM_ALL;
        default: acc.byte_mask = BM_TOP3;
      endcase
    end else begin
      acc.byte_mask = 8'($urandom);
    end
  endtask

  task automatic run_random_items(input int n);
    mem_access_t acc;
    for (int i = 0; i < n; i++) begin
      random_access(acc);
      send_access(acc);
    end
  endtask

  // extremes of fields, byte-mask shapes, folding, reservations, watchpoints
  task automatic test_directed_cases();
    mem_access_t list [$];
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    configure(SEED_Z_RST, SEED_W_RST, 3'd2,
              '{32'h0000_0100, 32'hE000_0010, 32'h1FFF_FFF8, 32'h0800_0100});
    list = '{
      make_access(ACT_WRITE, 32'h0000_0100, 0, 0, 64'h0123_4567_89AB_CDEF, BM_ALL),
      make_access(ACT_READ,  32'h0000_0100, 0, 0, 64'd0, 8'h00),
      // folded address still hits the watchpoint
      make_access(ACT_WRITE, 32'hA000_0100, 0, 0, 64'h12, 8'h80),
      make_access(ACT_WRITE, 32'h0000_0108, 0, 0, 64'hAB_CDEF, BM_TOP3),
      make_access(ACT_WRITE, 32'h0000_0108, 0, 0, 64'hFFFF, 8'h18),
      // masks without a supported shape leave the word alone
      make_access(ACT_WRITE, 32'h0000_0108, 0, 0, '1, 8'h05),
      make_access(ACT_WRITE, 32'h0000_0108, 0, 0, '1, 8'h00),
      make_access(ACT_WRITE, 32'h0000_010F, 0, 0, 64'h55AA, 8'h1E),
      make_access(ACT_READ,  32'h0000_0108, 0, 0, '1, BM_ALL),
      // store index wraps: same word as 0x100
      make_access(ACT_WRITE, 32'h0002_0100, 0, 0, '1, 8'h01),
      make_access(ACT_READ,  32'h0000_0100, 0, 0, 64'd0, 8'h00),
      // outside main memory
      make_access(ACT_WRITE, 32'h0800_0100, 0, 0, 64'hDEAD_BEEF, BM_ALL),
      make_access(ACT_READ,  32'h0800_0100, 0, 0, 64'd0, 8'h00),
      make_access(ACT_WRITE, 32'hE000_0010, 0, 0, 64'h1, BM_ALL),
      make_access(ACT_READ,  32'hFFFF_FFFF, 0, 0, 64'd0, 8'h00),
      make_access(ACT_WRITE, 32'h1FFF_FFF8, 0, 0, '1, BM_ALL),
      // conditional without reservation fails; address zero matches an empty slot
      make_access(ACT_WRITE, 32'h0000_0200, 0, 1, 64'h77, BM_ALL),
      make_access(ACT_WRITE, 32'h0000_0000, 0, 1, 64'h99, BM_ALL),
      make_access(ACT_READ,  32'h0000_0000, 1, 0, 64'd0, 8'h00),
      make_access(ACT_READ,  32'h0000_0200, 1, 0, 64'd0, 8'h00),
      make_access(ACT_READ,  32'h0000_0300, 1, 0, 64'd0, 8'h00),
      make_access(ACT_READ,  32'h0000_0400, 1, 0, 64'd0, 8'h00),
      make_access(ACT_WRITE, 32'h0002_0200, 0, 1, 64'h11, BM_ALL),
      make_access(ACT_WRITE, 32'h0000_0200, 0, 1, 64'h22, BM_ALL),
      make_access(ACT_WRITE, 32'h0000_0300, 0, 1, 64'h33, BM_ALL),
      make_access(ACT_WRITE, 32'h0000_0400, 0, 1, 64'h44, BM_ALL),
      make_access(ACT_WRITE, 32'h0000_0400, 1, 1, 64'h55, BM_ALL),
      make_access(ACT_READ,  32'h0000_0200, 0, 1, 64'd0, 8'h00)
    };
    foreach (list[i]) send_access(list[i]);
    drain_port();
  endtask

  // sender idle chance 29 percent, receiver 46; generator seeds all ones
  task automatic test_slow_receiver();
    refresh_hot_addrs();
    snd_idle_pct = 29;
    rcv_idle_pct = 46;
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7,
              '{hot_addr[1], hot_addr[7], hot_addr[6], hot_addr[5]});
    run_random_items(RANDOM_ITEMS);
    drain_port();
  endtask

  // sender idles 46, receiver 29; zero seeds, watchpoints off
  task automatic test_slow_sender();
    refresh_hot_addrs();
    snd_idle_pct = 46;
    rcv_idle_pct = 29;
    configure(32'd0, 32'd0, 3'd0, '{hot_addr[2], hot_addr[3], $urandom, $urandom});
    run_random_items(RANDOM_ITEMS);
    drain_port();
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_output_backpressure();
    refresh_hot_addrs();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    configure($urandom, $urandom, 3'd3, '{hot_addr[0], hot_addr[4], hot_addr[7], hot_addr[1]});
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    run_random_items(40);
    drain_port();
  endtask

  // items offered back to back, no random idling on either side
  task automatic test_full_rate();
    refresh_hot_addrs();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    configure($urandom, $urandom, 3'd4, '{hot_addr[1], hot_addr[2], hot_addr[5], hot_addr[7]});
    run_random_items(RANDOM_ITEMS);
    drain_port();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_READ;
    in_ch.address      = '0;
    in_ch.reserve      = 1'b0;
    in_ch.conditional  = 1'b0;
    in_ch.write_data   = '0;
    in_ch.byte_mask    = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    reset_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_slow_receiver();
    test_slow_sender();
    test_output_backpressure();
    test_full_rate();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
